// ===== hw/rtl/dst_pkg.sv =====
// Shared types, constants and helper functions for the descriptor slot table.
// Used by the state RAM, the core and the testbench; depends on nothing.
`timescale 1ns / 1ps

package dst_pkg;

    // Table geometry. Slot states are kept in rows of ROW_SLOTS slots.
    localparam int TABLE_DEPTH = 1024;
    localparam int FD_W        = 12;
    localparam int DESC_W      = 16;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COL_W       = 5;
    localparam int ROW_SLOTS   = 1 << COL_W;
    localparam int ROWS        = (TABLE_DEPTH + ROW_SLOTS - 1) / ROW_SLOTS;
    localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWPOS_W    = ROW_AW + COL_W;

    localparam logic [FD_W:0] FD_LIMIT = (FD_W + 1)'(TABLE_DEPTH);

    // Slot state codes.
    localparam logic [1:0] SLOT_EMPTY    = 2'd0;
    localparam logic [1:0] SLOT_RESERVED = 2'd1;
    localparam logic [1:0] SLOT_BOUND    = 2'd2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_BIND    = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLOSE   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUP     = 3'd4;
    localparam logic [OP_W-1:0] OP_DUP2    = 3'd5;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BADFD = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    typedef logic [1:0] slot_code_t;
    typedef slot_code_t [ROW_SLOTS-1:0] state_row_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] addr;
        state_row_t        row;
        logic              has_free;
    } row_wr_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [FD_W-1:0]   target_fd;
        logic [FD_W-1:0]   second_fd;
        logic [DESC_W-1:0] description_id;
    } in_item_t;

    typedef struct packed {
        logic [FD_W-1:0]     result_fd;
        logic [DESC_W-1:0]   result_description;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // Index of the lowest row whose summary bit is set.
    function automatic logic [ROW_AW-1:0] lowest_row(input logic [ROWS-1:0] v);
        logic [ROW_AW-1:0] idx;
        idx = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = ROW_AW'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest set bit within one row.
    function automatic logic [COL_W-1:0] lowest_col(input logic [ROW_SLOTS-1:0] v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = ROW_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

    // Marks the slots of a row that lie inside the table.
    function automatic logic [ROW_SLOTS-1:0] row_mask(input logic [ROW_AW-1:0] row);
        logic [ROW_SLOTS-1:0] m;
        for (int c = 0; c < ROW_SLOTS; c++) begin
            m[c] = (int'(row) * ROW_SLOTS + c) < TABLE_DEPTH;
        end
        return m;
    endfunction

    // Empty, in-range slots of a row.
    function automatic logic [ROW_SLOTS-1:0] empty_bits(input state_row_t r,
                                                        input logic [ROW_AW-1:0] row);
        logic [ROW_SLOTS-1:0] m;
        logic [ROW_SLOTS-1:0] e;
        m = row_mask(row);
        for (int c = 0; c < ROW_SLOTS; c++) begin
            e[c] = (r[c] == SLOT_EMPTY) && m[c];
        end
        return e;
    endfunction

endpackage

// ===== hw/rtl/dst_desc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the description handles; no dependencies.
`timescale 1ns / 1ps

module dst_desc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/dst_state_ram.sv =====
// Row memory of slot states with per-row valid bits and a per-row free summary.
// Depends on dst_pkg.
`timescale 1ns / 1ps

module dst_state_ram (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [dst_pkg::ROW_AW-1:0] rd_addr,
    output dst_pkg::state_row_t        rd_row,
    input  dst_pkg::row_wr_t           wr,
    output logic [dst_pkg::ROW_AW-1:0] free_row,
    output logic                       any_free
);

    dst_pkg::state_row_t         mem [dst_pkg::ROWS];
    dst_pkg::state_row_t         rd_data_reg;
    logic                        rd_valid_reg;
    logic [dst_pkg::ROWS-1:0]    row_valid_reg;
    logic [dst_pkg::ROWS-1:0]    row_free_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.row;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A row that was never written reads as all empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            row_free_reg  <= '1;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                row_valid_reg[wr.addr] <= 1'b1;
                row_free_reg[wr.addr]  <= wr.has_free;
            end
            if (rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row   = rd_valid_reg ? rd_data_reg : {dst_pkg::ROW_SLOTS{dst_pkg::SLOT_EMPTY}};
    assign free_row = dst_pkg::lowest_row(row_free_reg);
    assign any_free = |row_free_reg;

endmodule

// ===== hw/rtl/descriptor_slot_table_core.sv =====
// Descriptor slot table: top level with the operation sequencer and result register.
// Depends on dst_pkg, dst_state_ram and dst_desc_ram.
`timescale 1ns / 1ps

// Each item passes through three steps from acceptance to a loaded result: the accept
// cycle reads the state row of target_fd and its description handle, the second
// step reads the destination row (the lowest row with an empty slot, or the row
// of second_fd for dup2), and the third decides the outcome, writes the one
// modified state row and any handle back, and loads the result register. These
// three steps around the single read port of the state row memory set the rate; a new item
// is taken in the cycle after the third, and the third step holds while the
// result register is still full. Slot states live in rows of 32 with one valid
// bit per row, so the table is usable in the first cycle after reset with no
// clearing pass. A summary bit per row marks rows with an empty slot, which
// makes the lowest-empty search a short priority encode over the summary and
// then over one row.

module descriptor_slot_table_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dst_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output dst_pkg::out_item_t m_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EX   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    dst_pkg::in_item_t   item_reg;
    dst_pkg::state_row_t row_a_reg;
    dst_pkg::out_item_t  m_item_reg;
    logic                m_valid_reg;

    logic accept;
    logic commit;

    // Memory interfaces.
    logic                         st_rd_en;
    logic [dst_pkg::ROW_AW-1:0]   st_rd_addr;
    dst_pkg::state_row_t          row_b;
    dst_pkg::row_wr_t             state_wr;
    logic [dst_pkg::ROW_AW-1:0]   free_row;
    logic                         any_free;
    logic [dst_pkg::DESC_W-1:0]   desc_rd;
    logic                         desc_we;
    logic [dst_pkg::IDX_W-1:0]    desc_waddr;
    logic [dst_pkg::DESC_W-1:0]   desc_wdata;

    // Decoded fields of the held item.
    logic [dst_pkg::ROW_AW-1:0]   a_row;
    logic [dst_pkg::ROW_AW-1:0]   b_row;
    logic [dst_pkg::ROW_AW-1:0]   rowb_addr;
    logic [dst_pkg::COL_W-1:0]    a_col;
    logic [dst_pkg::COL_W-1:0]    b_col;
    logic [dst_pkg::COL_W-1:0]    new_col;
    logic [dst_pkg::ROWPOS_W-1:0] new_pos;
    logic                         a_ok;
    logic                         b_ok;
    logic                         a_res;
    logic                         a_bound;

    // Result of the decision step.
    logic                         wr_en_c;
    logic [dst_pkg::ROW_AW-1:0]   wr_addr_c;
    dst_pkg::state_row_t          wr_row_c;
    logic                         desc_we_c;
    dst_pkg::out_item_t           result_c;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_EX) && (!m_valid_reg || m_ready);

    assign a_row     = item_reg.target_fd[dst_pkg::COL_W +: dst_pkg::ROW_AW];
    assign b_row     = item_reg.second_fd[dst_pkg::COL_W +: dst_pkg::ROW_AW];
    assign a_col     = item_reg.target_fd[dst_pkg::COL_W-1:0];
    assign b_col     = item_reg.second_fd[dst_pkg::COL_W-1:0];
    assign rowb_addr = (item_reg.operation == dst_pkg::OP_DUP2) ? b_row : free_row;

    // The state row of the target slot is read at acceptance; the destination row
    // is read in the next cycle.
    assign st_rd_en   = accept || (state_reg == ST_RD);
    assign st_rd_addr = accept ? s_item.target_fd[dst_pkg::COL_W +: dst_pkg::ROW_AW]
                               : rowb_addr;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_EX;
            end
            ST_EX: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        if (state_reg == ST_RD) begin
            row_a_reg <= row_b;
        end
        if (commit) begin
            m_item_reg <= result_c;
        end
    end

    // Decision step. row_b holds the destination row and row_a_reg the target row;
    // when both are the same row they are the same unmodified copy.
    always_comb begin
        logic [dst_pkg::ROW_SLOTS-1:0] free_bits;

        free_bits = dst_pkg::empty_bits(row_b, free_row);
        new_col   = dst_pkg::lowest_col(free_bits);
        new_pos   = {free_row, new_col};
        a_ok      = {1'b0, item_reg.target_fd} < dst_pkg::FD_LIMIT;
        b_ok      = {1'b0, item_reg.second_fd} < dst_pkg::FD_LIMIT;
        a_res     = a_ok && (row_a_reg[a_col] == dst_pkg::SLOT_RESERVED);
        a_bound   = a_ok && (row_a_reg[a_col] == dst_pkg::SLOT_BOUND);

        wr_en_c    = 1'b0;
        wr_addr_c  = a_row;
        wr_row_c   = row_a_reg;
        desc_we_c  = 1'b0;
        desc_waddr = item_reg.target_fd[dst_pkg::IDX_W-1:0];
        desc_wdata = item_reg.description_id;
        result_c   = '{result_fd: '0, result_description: '0, status: dst_pkg::STS_BADFD};

        case (item_reg.operation)
            dst_pkg::OP_ALLOC: begin
                if (!any_free) begin
                    result_c.status = dst_pkg::STS_FULL;
                end else begin
                    wr_en_c           = 1'b1;
                    wr_addr_c         = rowb_addr;
                    wr_row_c          = row_b;
                    wr_row_c[new_col] = dst_pkg::SLOT_RESERVED;
                    result_c.result_fd = dst_pkg::FD_W'(new_pos);
                    result_c.status    = dst_pkg::STS_OK;
                end
            end
            dst_pkg::OP_BIND: begin
                if (a_res) begin
                    wr_en_c         = 1'b1;
                    wr_row_c[a_col] = dst_pkg::SLOT_BOUND;
                    desc_we_c       = 1'b1;
                    result_c.status = dst_pkg::STS_OK;
                end
            end
            dst_pkg::OP_RELEASE: begin
                if (a_res) begin
                    wr_en_c         = 1'b1;
                    wr_row_c[a_col] = dst_pkg::SLOT_EMPTY;
                    result_c.status = dst_pkg::STS_OK;
                end else if (a_bound) begin
                    result_c.status = dst_pkg::STS_OK;
                end
            end
            dst_pkg::OP_CLOSE: begin
                if (a_bound) begin
                    wr_en_c         = 1'b1;
                    wr_row_c[a_col] = dst_pkg::SLOT_EMPTY;
                    result_c.status = dst_pkg::STS_OK;
                end
            end
            dst_pkg::OP_DUP: begin
                if (a_ok) begin
                    if (!any_free) begin
                        result_c.status = dst_pkg::STS_FULL;
                    end else if (a_bound) begin
                        wr_en_c           = 1'b1;
                        wr_addr_c         = rowb_addr;
                        wr_row_c          = row_b;
                        wr_row_c[new_col] = dst_pkg::SLOT_BOUND;
                        desc_we_c         = 1'b1;
                        desc_waddr        = dst_pkg::IDX_W'(new_pos);
                        desc_wdata        = desc_rd;
                        result_c.result_fd = dst_pkg::FD_W'(new_pos);
                        result_c.status    = dst_pkg::STS_OK;
                    end
                end
            end
            dst_pkg::OP_DUP2: begin
                if (a_bound && b_ok) begin
                    wr_en_c         = 1'b1;
                    wr_addr_c       = rowb_addr;
                    wr_row_c        = row_b;
                    wr_row_c[b_col] = dst_pkg::SLOT_BOUND;
                    desc_we_c       = 1'b1;
                    desc_waddr      = item_reg.second_fd[dst_pkg::IDX_W-1:0];
                    desc_wdata      = desc_rd;
                    result_c.result_fd = item_reg.second_fd;
                    result_c.status    = dst_pkg::STS_OK;
                end
            end
            dst_pkg::OP_LOOKUP: begin
                if (a_bound) begin
                    result_c.result_description = desc_rd;
                    result_c.status             = dst_pkg::STS_OK;
                end
            end
            default: begin
                result_c.status = dst_pkg::STS_BADFD;
            end
        endcase
    end

    assign state_wr.en       = wr_en_c && commit;
    assign state_wr.addr     = wr_addr_c;
    assign state_wr.row      = wr_row_c;
    assign state_wr.has_free = |dst_pkg::empty_bits(wr_row_c, wr_addr_c);
    assign desc_we           = desc_we_c && commit;

    dst_state_ram u_state_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (st_rd_en),
        .rd_addr  (st_rd_addr),
        .rd_row   (row_b),
        .wr       (state_wr),
        .free_row (free_row),
        .any_free (any_free)
    );

    // The handle of the target slot is read at acceptance and held for the item.
    dst_desc_ram #(
        .DEPTH (dst_pkg::TABLE_DEPTH),
        .WIDTH (dst_pkg::DESC_W)
    ) u_desc_ram (
        .aclk    (aclk),
        .wr_en   (desc_we),
        .wr_addr (desc_waddr),
        .wr_data (desc_wdata),
        .rd_en   (accept),
        .rd_addr (s_item.target_fd[dst_pkg::IDX_W-1:0]),
        .rd_data (desc_rd)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // An accepted item always moves on to the destination row read.
    a_accept_to_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RD))
        else $error("accepted item did not enter the row read step");

    // The state memory is written only in the decision step with room for the result.
    a_write_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_wr.en |-> ((state_reg == ST_EX) && (!m_valid_reg || m_ready)))
        else $error("state row written outside the commit cycle");

    // Only bind, dup and dup2 store a handle.
    a_desc_write_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        desc_we |-> ((item_reg.operation == dst_pkg::OP_BIND) ||
                     (item_reg.operation == dst_pkg::OP_DUP) ||
                     (item_reg.operation == dst_pkg::OP_DUP2)))
        else $error("handle written by an operation that does not store one");

    // A failed item reports no slot and no handle.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.status != dst_pkg::STS_OK)) |->
            ((m_item.result_fd == '0) && (m_item.result_description == '0)))
        else $error("error result carries a slot or a handle");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for descriptor_slot_table_core: a slot table allocator with
// bind, release, close, dup, dup2 and lookup. Depends on dst_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import dst_pkg::*;

    // Operation code 7 has no meaning in the block and must come back as a bad descriptor.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int IDLE_PCT        = 35;
    localparam int RANDOM_ITEMS    = 750;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 10;

    // The scoreboard carries its own copy of the slot table. Every accepted item is
    // applied to that copy at once, in acceptance order, and the result it should give
    // is queued. Results from the block are checked against the head of that queue.
    class slot_table_scoreboard;
        slot_code_t        slot_st[TABLE_DEPTH];
        logic [DESC_W-1:0] slot_desc[TABLE_DEPTH];
        out_item_t         pending_q[$];
        logic [FD_W-1:0]   last_alloc_fd;
        int unsigned       mismatches;
        int unsigned       results_seen;
        int unsigned       status_seen[3];
        int unsigned       full_hits;

        function new();
            foreach (slot_st[i]) begin
                slot_st[i]   = SLOT_EMPTY;
                slot_desc[i] = '0;
            end
            last_alloc_fd = '0;
            mismatches    = 0;
            results_seen  = 0;
            full_hits     = 0;
            foreach (status_seen[i]) begin
                status_seen[i] = 0;
            end
        endfunction

        function int lowest_empty();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_st[i] == SLOT_EMPTY) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Some slot in the given state, searched from a random starting point; -1 if none.
        function int find_slot(slot_code_t code);
            int start;
            int idx;
            start = $urandom_range(TABLE_DEPTH - 1);
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                idx = (start + k) % TABLE_DEPTH;
                if (slot_st[idx] == code) begin
                    return idx;
                end
            end
            return -1;
        endfunction

        // Applies one operation to the table copy and returns the result it must give.
        function out_item_t apply_op(in_item_t it);
            out_item_t r;
            int        slot;
            bit        a_ok;
            bit        b_ok;
            bit        a_bound;
            r        = '0;
            r.status = STS_BADFD;
            a_ok     = it.target_fd < TABLE_DEPTH;
            b_ok     = it.second_fd < TABLE_DEPTH;
            a_bound  = a_ok && (slot_st[it.target_fd] == SLOT_BOUND);
            case (it.operation)
                OP_ALLOC: begin
                    slot = lowest_empty();
                    if (slot < 0) begin
                        r.status = STS_FULL;
                    end else begin
                        slot_st[slot] = SLOT_RESERVED;
                        r.result_fd   = FD_W'(slot);
                        r.status      = STS_OK;
                    end
                end
                OP_BIND: begin
                    if (a_ok && slot_st[it.target_fd] == SLOT_RESERVED) begin
                        slot_st[it.target_fd]   = SLOT_BOUND;
                        slot_desc[it.target_fd] = it.description_id;
                        r.status                = STS_OK;
                    end
                end
                OP_RELEASE: begin
                    // A bound slot already used its reservation: ok, but nothing changes.
                    if (a_ok && slot_st[it.target_fd] == SLOT_RESERVED) begin
                        slot_st[it.target_fd] = SLOT_EMPTY;
                        r.status              = STS_OK;
                    end else if (a_bound) begin
                        r.status = STS_OK;
                    end
                end
                OP_CLOSE: begin
                    if (a_bound) begin
                        slot_st[it.target_fd]   = SLOT_EMPTY;
                        slot_desc[it.target_fd] = '0;
                        r.status                = STS_OK;
                    end
                end
                OP_DUP: begin
                    // Range check first, then the full check, then the source state.
                    if (a_ok) begin
                        slot = lowest_empty();
                        if (slot < 0) begin
                            r.status = STS_FULL;
                        end else if (a_bound) begin
                            slot_st[slot]   = SLOT_BOUND;
                            slot_desc[slot] = slot_desc[it.target_fd];
                            r.result_fd     = FD_W'(slot);
                            r.status        = STS_OK;
                        end
                    end
                end
                OP_DUP2: begin
                    if (a_bound && b_ok) begin
                        slot_desc[it.second_fd] = slot_desc[it.target_fd];
                        slot_st[it.second_fd]   = SLOT_BOUND;
                        r.result_fd             = it.second_fd;
                        r.status                = STS_OK;
                    end
                end
                OP_LOOKUP: begin
                    if (a_bound) begin
                        r.result_description = slot_desc[it.target_fd];
                        r.status             = STS_OK;
                    end
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_input(in_item_t it);
            out_item_t r;
            r = apply_op(it);
            if (it.operation == OP_ALLOC && r.status == STS_OK) begin
                last_alloc_fd = r.result_fd;
            end
            if (r.status == STS_FULL) begin
                full_hits++;
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_seen++;
            if (got.status <= STS_FULL) begin
                status_seen[got.status]++;
            end
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result with nothing pending: fd=%0d desc=%h status=%0d",
                             got.result_fd, got.result_description, got.status);
                end
                return;
            end
            want = pending_q.pop_front();
            if (got.result_fd !== want.result_fd ||
                got.result_description !== want.result_description ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result %0d: expected fd=%0d desc=%h status=%0d,",
                             results_seen, want.result_fd, want.result_description,
                             want.status);
                    $display("       got fd=%0d desc=%h status=%0d",
                             got.result_fd, got.result_description, got.status);
                end
            end
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;

    slot_table_scoreboard sb;

    // Quiet turns off idling on both sides; hold_req asks the receiver for a long hold-off.
    bit          quiet        = 1'b0;
    bit          hold_req     = 1'b0;
    int unsigned stall_cycles = 0;
    int unsigned items_sent   = 0;

    descriptor_slot_table_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Cycles in a row with no handshake on either channel. The longest legitimate gap
    // is the receiver hold-off, well under the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("ERROR: no handshake for %0d cycles, %0d results still pending",
                 STALL_LIMIT, sb.pending_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Result side. Outputs are sampled at the rising edge, so a result counts as taken
    // when m_valid and m_ready were both high just before the edge. After sampling, the
    // ready for the next cycle is chosen: random, always high while quiet, or held low
    // for a long stretch on request so the block backs up into its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_item);
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offers one item, with random idle cycles ahead of it, and returns at the edge
    // that accepts it. Valid stays high from one item to the next unless an idle cycle
    // is inserted, and an idle always lasts at least one full cycle.
    task automatic send_item(input in_item_t it);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input int a = 0, input int b = 0,
                         input int d = 0);
        in_item_t it;
        it.operation      = op;
        it.target_fd      = FD_W'(a);
        it.second_fd      = FD_W'(b);
        it.description_id = DESC_W'(d);
        send_item(it);
    endtask

    // Stops offering items until every pending result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Slot index for random items. Most picks land on live slots or near the bottom of
    // the table, where allocation happens; the rest cover the top end and the whole
    // out-of-range space so that every index bit toggles.
    function automatic int pick_fd();
        int idx;
        case ($urandom_range(9))
            0: begin
                return $urandom_range(4095);
            end
            1: begin
                return $urandom_range(4095, TABLE_DEPTH);
            end
            2: begin
                return TABLE_DEPTH - 1 - $urandom_range(3);
            end
            3, 4: begin
                return $urandom_range(63);
            end
            5: begin
                idx = sb.find_slot(SLOT_RESERVED);
            end
            default: begin
                idx = sb.find_slot(SLOT_BOUND);
            end
        endcase
        return (idx < 0) ? $urandom_range(TABLE_DEPTH - 1) : idx;
    endfunction

    task automatic random_item();
        issue(OP_W'($urandom_range(7)), pick_fd(), pick_fd(), $urandom);
    endtask

    // A well-formed life of one slot: allocate, bind, then a few uses of the handle,
    // and usually a close at the end. Some allocations are given back unbound instead.
    task automatic slot_lifecycle();
        int fd;
        issue(OP_ALLOC, $urandom, $urandom, $urandom);
        fd = sb.last_alloc_fd;
        if ($urandom_range(9) == 0) begin
            issue(OP_RELEASE, fd, $urandom, $urandom);
            return;
        end
        issue(OP_BIND, fd, $urandom, $urandom);
        repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(4))
                0: issue(OP_LOOKUP, fd, $urandom, $urandom);
                1: issue(OP_DUP, fd, $urandom, $urandom);
                2: issue(OP_DUP2, fd, pick_fd(), $urandom);
                3: issue(OP_RELEASE, fd, $urandom, $urandom);
                default: issue(OP_CLOSE, pick_fd(), $urandom, $urandom);
            endcase
        end
        if ($urandom_range(2) != 0) begin
            issue(OP_CLOSE, fd, $urandom, $urandom);
        end
    endtask

    // Random traffic until the given number of further items has been accepted.
    task automatic random_run(input int count, input int hold_at);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if (hold_at >= 0 && items_sent >= stop - count + hold_at && !hold_req) begin
                hold_req = 1'b1;
                hold_at  = -1;
            end
            if ($urandom_range(9) < 6) begin
                slot_lifecycle();
            end else begin
                random_item();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks on a fresh table, one per rule of the block.
        issue(OP_LOOKUP, 0);                            // Lookup on an empty slot.
        issue(OP_ALLOC);                                // Gets slot 0.
        issue(OP_ALLOC);                                // Gets slot 1.
        issue(OP_BIND, 0, 0, 16'hFFFF);
        issue(OP_BIND, 1, 0, 16'h0000);
        issue(OP_BIND, 0, 0, 16'h1234);                 // Already bound.
        issue(OP_RELEASE, 0);                           // Bound: ok, no change.
        issue(OP_ALLOC);                                // Gets slot 2.
        issue(OP_RELEASE, 2);                           // Reservation given back.
        issue(OP_RELEASE, 2);                           // Now empty: bad descriptor.
        issue(OP_LOOKUP, 0);
        issue(OP_DUP, 0);                               // Copies into slot 2.
        issue(OP_DUP, 4095);
        issue(OP_DUP, TABLE_DEPTH);
        issue(OP_DUP, TABLE_DEPTH - 1);                 // Empty source, slot 3 stays empty.
        issue(OP_DUP2, 0, TABLE_DEPTH - 1);             // Onto an empty slot at the top.
        issue(OP_ALLOC);                                // Gets slot 3.
        issue(OP_DUP2, 1, 3);                           // Overwrites a reservation.
        issue(OP_DUP2, 0, 1);                           // Overwrites a bound slot.
        issue(OP_DUP2, 0, 0);                           // Same source and destination.
        issue(OP_DUP2, 0, 4095);
        issue(OP_CLOSE, TABLE_DEPTH - 1);
        issue(OP_CLOSE, TABLE_DEPTH - 1);               // Already closed.
        issue(OP_LOOKUP, TABLE_DEPTH - 1);
        issue(OP_UNUSED, 0, 0, 16'hA5A5);
        issue(OP_BIND, 4095, 4095, 16'hFFFF);

        // First random half, with a long receiver hold-off early on and a full drain after each quarter.
        random_run(RANDOM_ITEMS / 4, 60);
        drain();
        random_run(RANDOM_ITEMS / 4, -1);
        drain();

        // Second random half: the first stretch runs with no idling on either side.
        quiet = 1'b1;
        random_run(RANDOM_ITEMS / 4, -1);
        quiet = 1'b0;
        random_run(RANDOM_ITEMS / 4, -1);

        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d items of every operation, a long receiver hold-off,",
                 items_sent);
        $display("two drains and %0d table-full results: %0d ok, %0d bad descriptor.",
                 sb.full_hits, sb.status_seen[0], sb.status_seen[1]);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
